FILE: src/kabf_pkg.sv
// Shared types, constants and helpers for the angle/bias Kalman filter.
package kabf_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int CFG_W = 31;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [IDX_W-1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_MEAS_NOISE  = 2'd2;

    typedef struct packed {
        logic signed [31:0] measured_angle;
        logic signed [31:0] gyro_rate;
        logic [15:0]        time_step;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] angle_estimate;
        logic signed [31:0] corrected_rate;
    } out_word_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,     // rate = gyro - bias
        ST_M_RDT,    // mul rate*dt
        ST_ANG,      // angle += .
        ST_M_P11DT,  // p11*dt
        ST_T1,       // t = p11dt - p01 - p10 + q
        ST_M_TDT,    // t*dt; q_bias*dt launched
        ST_PRED,     // p00,p01,p10 updated
        ST_P11,
        ST_S,
        ST_DIV0_GO,
        ST_DIV0_WT,
        ST_DIV1_GO,
        ST_DIV1_WT,
        ST_Y,
        ST_M_K0Y,
        ST_M_K1Y,
        ST_M_K0P00,
        ST_M_K0P01,
        ST_M_K1P00,
        ST_M_K1P01,
        ST_DONE,
        ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] add_s(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return sat32(66'(a) + 66'(b));
    endfunction

    function automatic logic signed [31:0] sub_s(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return sat32(66'(a) - 66'(b));
    endfunction

endpackage

FILE: src/kabf_div.sv
// Radix-2 restoring divider for the gains: sat32((num << FRAC_BITS) / den).
module kabf_div #(
    parameter int FRAC_BITS = kabf_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quot
);
    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] q_reg, q_next;
    logic [32:0]   r_reg, r_next;
    logic [31:0]   d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [33:0]   trial;
    logic [NW:0]   sq;

    always_comb begin
        n_next    = n_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, n_reg[NW-1]} - {2'b00, d_reg};
        if (start) begin
            n_next    = NW'(num[31] ? -{{FRAC_BITS{num[31]}}, num}
                                    : {{FRAC_BITS{num[31]}}, num}) << FRAC_BITS;
            d_next    = den[31] ? 32'(-den) : den;
            neg_next  = num[31] ^ den[31];
            r_next    = '0;
            q_next    = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            n_next = n_reg << 1;
            if (!trial[33]) begin
                r_next = trial[32:0];
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = {r_reg[31:0], n_reg[NW-1]};
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        n_reg   <= n_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    always_comb begin
        sq = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
        if (!neg_reg && q_reg > NW'(32'h7FFFFFFF)) quot = 32'sh7FFFFFFF;
        else if (neg_reg && q_reg > NW'(33'h80000000)) quot = 32'sh80000000;
        else quot = sq[31:0];
    end

    assign done = done_reg;
endmodule

FILE: src/kalman_angle_bias_filter.sv
// Two-state angle/gyro-bias Kalman filter, Q-format fixed point, shared multiplier and divider.
// A word is taken only while idle, and the next word only once the last result is in the
// output register. The two gain divisions run on the one restoring divider, a bit per
// cycle, and all products go through one shared 32x32 multiplier with two register
// stages; the default FRAC_BITS gives Q16.16 words. s_ready is
// high only while idle. A finished result waits in the output register until taken; a
// new word may be taken meanwhile, and its result is held back until the slot is free.
// Register writes take effect at once and must be made while idle.
module kalman_angle_bias_filter #(
    parameter int FRAC_BITS = kabf_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [kabf_pkg::IDX_W-1:0]         cfg_index,
    input  logic [kabf_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  kabf_pkg::in_word_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output kabf_pkg::out_word_t                m_data
);
    localparam longint ONE_Q = longint'(1) << FRAC_BITS;
    localparam longint SF_RAW = (ONE_Q + 500) / 1000;
    localparam logic signed [31:0] S_FLOOR = 32'(SF_RAW > 0 ? SF_RAW : 1);
    localparam logic [30:0] RST_AN = 31'((ONE_Q + 500) / 1000);
    localparam logic [30:0] RST_BN = 31'((ONE_Q * 3 + 500) / 1000);
    localparam logic [30:0] RST_MN = 31'((ONE_Q * 30) / 1000);

    logic [30:0] qa_reg, qb_reg, rm_reg;
    kabf_pkg::state_t st_reg, st_next;

    logic signed [31:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] meas_reg, gyro_reg, rate_reg, t_reg, s_reg, k0_reg, k1_reg, y_reg;
    logic signed [31:0] o00_reg, o01_reg;
    logic [15:0]        dt_reg;
    kabf_pkg::out_word_t out_reg;
    logic               mv_reg;

    // shared multiplier: operands chosen by state, product registered, then rounded and
    // registered again; a product launched in one state passes prod_reg and then mres_reg before use
    logic signed [31:0] ma, mb;
    logic               m_dt;
    logic signed [63:0] prod_reg;
    logic               pdt_reg;
    logic signed [31:0] mres_next, mres_reg;
    logic signed [65:0] rnd;

    logic               dv_start, dv_done;
    logic signed [31:0] dv_num, dv_q;

    kabf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .num(dv_num),
        .den(s_reg), .done(dv_done), .quot(dv_q)
    );

    always_comb begin
        ma = k0_reg; mb = y_reg; m_dt = 1'b0;
        unique case (st_reg)
            kabf_pkg::ST_RATE:    begin ma = kabf_pkg::sub_s(gyro_reg, bias_reg);
                                        mb = {16'd0, dt_reg}; m_dt = 1'b1; end
            kabf_pkg::ST_ANG:     begin ma = p11_reg; mb = {16'd0, dt_reg}; m_dt = 1'b1; end
            kabf_pkg::ST_T1:      begin ma = kabf_pkg::add_s(kabf_pkg::sub_s(
                                            kabf_pkg::sub_s(mres_reg, p01_reg), p10_reg),
                                            {1'b0, qa_reg});
                                        mb = {16'd0, dt_reg}; m_dt = 1'b1; end
            kabf_pkg::ST_M_TDT:   begin ma = {1'b0, qb_reg}; mb = {16'd0, dt_reg};
                                        m_dt = 1'b1; end
            kabf_pkg::ST_Y:       begin ma = k0_reg;
                                        mb = kabf_pkg::sub_s(meas_reg, ang_reg); end
            kabf_pkg::ST_M_K0Y:   begin ma = k1_reg; mb = y_reg; end
            kabf_pkg::ST_M_K1Y:   begin ma = k0_reg; mb = o00_reg; end
            kabf_pkg::ST_M_K0P00: begin ma = k0_reg; mb = o01_reg; end
            kabf_pkg::ST_M_K0P01: begin ma = k1_reg; mb = o00_reg; end
            kabf_pkg::ST_M_K1P00: begin ma = k1_reg; mb = o01_reg; end
            default: ;
        endcase
    end

    always_comb begin
        if (pdt_reg) rnd = (66'(prod_reg) + 66'sd32768) >>> 16;
        else rnd = (66'(prod_reg) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        mres_next = kabf_pkg::sat32(rnd);
    end

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            kabf_pkg::ST_IDLE:    if (s_valid && s_ready) st_next = kabf_pkg::ST_RATE;
            kabf_pkg::ST_RATE:    st_next = kabf_pkg::ST_M_RDT;
            kabf_pkg::ST_M_RDT:   st_next = kabf_pkg::ST_ANG;
            kabf_pkg::ST_ANG:     st_next = kabf_pkg::ST_M_P11DT;
            kabf_pkg::ST_M_P11DT: st_next = kabf_pkg::ST_T1;
            kabf_pkg::ST_T1:      st_next = kabf_pkg::ST_M_TDT;
            kabf_pkg::ST_M_TDT:   st_next = kabf_pkg::ST_PRED;
            kabf_pkg::ST_PRED:    st_next = kabf_pkg::ST_P11;
            kabf_pkg::ST_P11:     st_next = kabf_pkg::ST_S;
            kabf_pkg::ST_S:       st_next = kabf_pkg::ST_DIV0_GO;
            kabf_pkg::ST_DIV0_GO: st_next = kabf_pkg::ST_DIV0_WT;
            kabf_pkg::ST_DIV0_WT: if (dv_done) st_next = kabf_pkg::ST_DIV1_GO;
            kabf_pkg::ST_DIV1_GO: st_next = kabf_pkg::ST_DIV1_WT;
            kabf_pkg::ST_DIV1_WT: if (dv_done) st_next = kabf_pkg::ST_Y;
            kabf_pkg::ST_Y:       st_next = kabf_pkg::ST_M_K0Y;
            kabf_pkg::ST_M_K0Y:   st_next = kabf_pkg::ST_M_K1Y;
            kabf_pkg::ST_M_K1Y:   st_next = kabf_pkg::ST_M_K0P00;
            kabf_pkg::ST_M_K0P00: st_next = kabf_pkg::ST_M_K0P01;
            kabf_pkg::ST_M_K0P01: st_next = kabf_pkg::ST_M_K1P00;
            kabf_pkg::ST_M_K1P00: st_next = kabf_pkg::ST_M_K1P01;
            kabf_pkg::ST_M_K1P01: st_next = kabf_pkg::ST_DONE;
            kabf_pkg::ST_DONE:    st_next = kabf_pkg::ST_OUT;
            kabf_pkg::ST_OUT:     if (!mv_reg || m_ready) st_next = kabf_pkg::ST_IDLE;
            default:              st_next = kabf_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready  = (st_reg == kabf_pkg::ST_IDLE);
        dv_start = (st_reg == kabf_pkg::ST_DIV0_GO) || (st_reg == kabf_pkg::ST_DIV1_GO);
        dv_num   = (st_reg == kabf_pkg::ST_DIV0_GO) ? p00_reg : p10_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= kabf_pkg::ST_IDLE;
            qa_reg   <= RST_AN;
            qb_reg   <= RST_BN;
            rm_reg   <= RST_MN;
            ang_reg  <= '0; bias_reg <= '0;
            p00_reg  <= '0; p01_reg <= '0; p10_reg <= '0; p11_reg <= '0;
            mv_reg   <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    kabf_pkg::REG_ANGLE_NOISE: qa_reg <= cfg_data;
                    kabf_pkg::REG_BIAS_NOISE:  qb_reg <= cfg_data;
                    kabf_pkg::REG_MEAS_NOISE:  rm_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (st_reg == kabf_pkg::ST_OUT && (!mv_reg || m_ready)) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
            unique case (st_reg)
                kabf_pkg::ST_ANG:     ang_reg <= kabf_pkg::add_s(ang_reg, mres_reg);
                kabf_pkg::ST_PRED: begin
                    p00_reg <= kabf_pkg::add_s(p00_reg, mres_reg);
                    p01_reg <= kabf_pkg::sub_s(p01_reg, t_reg);
                    p10_reg <= kabf_pkg::sub_s(p10_reg, t_reg);
                end
                kabf_pkg::ST_P11:     p11_reg <= kabf_pkg::add_s(p11_reg, mres_reg);
                kabf_pkg::ST_M_K1Y:   ang_reg <= kabf_pkg::add_s(ang_reg, mres_reg);
                kabf_pkg::ST_M_K0P00: bias_reg <= kabf_pkg::add_s(bias_reg, mres_reg);
                kabf_pkg::ST_M_K0P01: p00_reg <= kabf_pkg::sub_s(p00_reg, mres_reg);
                kabf_pkg::ST_M_K1P00: p01_reg <= kabf_pkg::sub_s(p01_reg, mres_reg);
                kabf_pkg::ST_M_K1P01: p10_reg <= kabf_pkg::sub_s(p10_reg, mres_reg);
                kabf_pkg::ST_DONE:    p11_reg <= kabf_pkg::sub_s(p11_reg, mres_reg);
                default: ;
            endcase
        end
        prod_reg <= ma * mb;
        pdt_reg  <= m_dt;
        mres_reg <= mres_next;
        if (st_reg == kabf_pkg::ST_IDLE) begin
            meas_reg <= s_data.measured_angle;
            gyro_reg <= s_data.gyro_rate;
            dt_reg   <= s_data.time_step;
        end
        if (st_reg == kabf_pkg::ST_RATE) rate_reg <= kabf_pkg::sub_s(gyro_reg, bias_reg);
        // p11*dt kept for the p01/p10 updates
        if (st_reg == kabf_pkg::ST_T1) t_reg <= mres_reg;
        if (st_reg == kabf_pkg::ST_S) begin
            if (kabf_pkg::add_s(p00_reg, {1'b0, rm_reg}) == 32'sd0) s_reg <= S_FLOOR;
            else s_reg <= kabf_pkg::add_s(p00_reg, {1'b0, rm_reg});
            o00_reg <= p00_reg;
            o01_reg <= p01_reg;
        end
        if (st_reg == kabf_pkg::ST_DIV0_WT && dv_done) k0_reg <= dv_q;
        if (st_reg == kabf_pkg::ST_DIV1_WT && dv_done) k1_reg <= dv_q;
        if (st_reg == kabf_pkg::ST_Y) y_reg <= kabf_pkg::sub_s(meas_reg, ang_reg);
        if (st_reg == kabf_pkg::ST_OUT && (!mv_reg || m_ready)) begin
            out_reg.angle_estimate <= ang_reg;
            out_reg.corrected_rate <= rate_reg;
        end
    end

    assign m_valid = mv_reg;
    assign m_data  = out_reg;
endmodule
